@@ rtl/gcd_euclidean_unit_assert.svh @@
// Assertion macros for the GCD unit's RTL, used by gcd_core.sv.
`ifndef GCD_EUCLIDEAN_UNIT_ASSERT_SVH
`define GCD_EUCLIDEAN_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GCD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("GCD unit: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("GCD unit: next-cycle check failed");

`endif

@@ rtl/gcd_pkg.sv @@
// Package with the types shared by the GCD unit's modules.
package gcd_pkg;

  // Status that the iterative core reports to the top level.
  typedef struct packed {
    logic busy;   // a pair is being reduced
    logic done;   // the result is valid this cycle and is taken
  } gcd_stat_t;

endpackage

@@ rtl/gcd_euclidean_unit.sv @@
// Top level of the GCD unit: input handshake, iterative core and output register.
// Each pair is reduced step by step (strip a factor of two, or subtract and halve) until
// an operand is zero, and the result then fills the output register; a pair with a zero
// operand needs no reduction step, and output stalls hold the result in the core. The next
// word is taken once the result has left the core. rst_n clears the sequencer and the
// output valid flag.
module gcd_euclidean_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_gcd_value
);
  import gcd_pkg::*;

  gcd_stat_t                stat;
  logic                     start;
  logic                     take;
  logic [OPERAND_WIDTH-1:0] opa, opb, result;
  logic                     out_valid_r;
  logic [31:0]              out_gcd_value_r;

  // Operands are cut or zero-extended to the datapath width.
  assign opa = OPERAND_WIDTH'(in_operand_a);
  assign opb = OPERAND_WIDTH'(in_operand_b);

  // A new word is taken whenever the core is idle, even while an earlier
  // result still waits in the output register.
  assign in_stall = stat.busy;
  assign start    = in_valid && !in_stall;

  // The core may hand over its result once the output register is free or
  // is being emptied in this same cycle.
  assign take = !out_valid_r || !out_stall;

  gcd_core #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .opa   (opa),
    .opb   (opb),
    .take  (take),
    .stat  (stat),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // The result word is cut or zero-extended to the 32-bit field.
  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_gcd_value_r <= 32'(result);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_gcd_value = out_gcd_value_r;

endmodule

@@ rtl/gcd_core.sv @@
// Iterative GCD core: one shared compare and subtract unit under a two-state sequencer.
`include "gcd_euclidean_unit_assert.svh"

module gcd_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] opa,
  input  logic [OPERAND_WIDTH-1:0] opb,
  input  logic                     take,
  output gcd_pkg::gcd_stat_t       stat,
  output logic [OPERAND_WIDTH-1:0] result
);
  import gcd_pkg::*;

  localparam int KW = $clog2(OPERAND_WIDTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                     state_r, state_nxt;
  logic [OPERAND_WIDTH-1:0] a_r, a_nxt;
  logic [OPERAND_WIDTH-1:0] b_r, b_nxt;
  logic [KW-1:0]            k_r, k_nxt;

  logic                     a_zero, b_zero, a_ge_b, finish;
  logic [OPERAND_WIDTH-1:0] big, sml, diff, survivor;

  // The shared unit: one magnitude compare and one subtract.
  assign a_zero   = (a_r == '0);
  assign b_zero   = (b_r == '0);
  assign a_ge_b   = (a_r >= b_r);
  assign big      = a_ge_b ? a_r : b_r;
  assign sml      = a_ge_b ? b_r : a_r;
  assign diff     = big - sml;
  assign survivor = a_zero ? b_r : a_r;

  // Restore the common factors of two that were stripped on the way.
  assign result = survivor << k_r;
  assign finish = (state_r == ST_RUN) && (a_zero || b_zero) && take;

  assign stat.busy = (state_r == ST_RUN);
  assign stat.done = finish;

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          a_nxt     = opa;
          b_nxt     = opb;
          k_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        priority if (a_zero || b_zero) begin
          if (take) begin
            state_nxt = ST_IDLE;
          end
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + KW'(1);
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_ge_b) begin
          a_nxt = diff >> 1;
        end else begin
          b_nxt = diff >> 1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
  end

  `GCD_ASSERT_SAME(a_start_idle, start, !stat.busy)
  `GCD_ASSERT_NEXT(a_done_frees, stat.done, !stat.busy)
  `GCD_ASSERT_NEXT(a_k_monotonic, stat.busy && !a_zero && !b_zero, k_r >= $past(k_r))
  `GCD_ASSERT_NEXT(a_start_loads, start, stat.busy && k_r == '0)

endmodule

@@ tb/gcd_result_checker.sv @@
// Checker for the GCD unit: predicts each result word and compares it with the block's output.
module gcd_result_checker #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_gcd_value,
  output int          pending_words,
  output int          fail_count,
  output int          checked_words
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] expected_gcd_q[$];

  // Euclid's remainder method at the datapath width, result cut to the field width.
  function automatic logic [31:0] euclid_gcd(input logic [31:0] a, input logic [31:0] b);
    int unsigned width;
    logic [63:0] mask;
    logic [63:0] larger;
    logic [63:0] smaller;
    logic [63:0] rem;
    width = OPERAND_WIDTH;
    if (width < 4) width = 4;
    if (width > 64) width = 64;
    mask = ~64'd0 >> (64 - width);
    larger = {32'd0, a} & mask;
    smaller = {32'd0, b} & mask;
    if (smaller > larger) begin
      rem = larger;
      larger = smaller;
      smaller = rem;
    end
    while (smaller != 64'd0) begin
      rem = larger % smaller;
      larger = smaller;
      smaller = rem;
    end
    return larger[31:0];
  endfunction

  initial begin
    pending_words = 0;
    fail_count = 0;
    checked_words = 0;
  end

  always @(posedge clk) begin
    logic [31:0] expected;
    if (!rst_n) begin
      expected_gcd_q.delete();
    end else begin
      // A word cannot leave in the cycle its pair enters, so the pop goes first.
      if (out_valid && !out_stall) begin
        if (expected_gcd_q.size() == 0) begin
          $display("%0t ns: GCD word %0d arrived with no pair pending", $time, out_gcd_value);
          fail_count++;
        end else begin
          expected = expected_gcd_q.pop_front();
          checked_words++;
          if (out_gcd_value !== expected) begin
            $display("%0t ns: gcd_value mismatch, expected %0d, actual %0d",
                     $time, expected, out_gcd_value);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_gcd_q.push_back(euclid_gcd(in_operand_a, in_operand_b));
      end
    end
    pending_words = expected_gcd_q.size();
  end

endmodule

@@ tb/tb_gcd_euclidean_unit.sv @@
// Top of the GCD unit testbench: clock, reset, operand stimulus, result receiver and verdict.
module tb_gcd_euclidean_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPERAND_WIDTH = 32;
  localparam int RANDOM_PAIRS = 800;
  localparam int IDLE_MAX = 6;
  // Extra wait after the final drain, sized from the operand width.
  localparam int DRAIN_CYCLES = 2 * OPERAND_WIDTH + 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_gcd_value;

  int pending_words;
  int fail_count;
  int checked_words;
  int sent_pairs = 0;

  // When set, the sender puts no gaps between its words for a while.
  logic sender_quiet = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  gcd_euclidean_unit #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_gcd_value(out_gcd_value)
  );

  gcd_result_checker #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_gcd_value(out_gcd_value),
    .pending_words(pending_words),
    .fail_count   (fail_count),
    .checked_words(checked_words)
  );

  // Offers one operand pair and returns at the edge where the word is taken. The valid
  // flag is only lowered when a gap is drawn, so back-to-back words keep it high and
  // each step sees a single assignment to it.
  task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_pairs++;
  endtask

  // Holds the sender off until the checker has nothing left to wait for. The counters are
  // read on the falling edge, where the checker's updates at the rising edge have settled.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Draws one random pair from a mix of shapes: fully random words, pairs sharing a large
  // factor, small values, a zero operand, equal operands and consecutive Fibonacci
  // numbers, which take the most remainder steps.
  task automatic send_random_pair();
    int unsigned shape;
    int unsigned factor;
    int unsigned steps;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] fib_next;
    shape = $urandom_range(0, 99);
    if (shape < 40) begin
      a = $urandom();
      b = $urandom();
    end else if (shape < 65) begin
      factor = $urandom_range(1, 65535);
      a = factor * $urandom_range(0, 65535);
      b = factor * $urandom_range(0, 65535);
    end else if (shape < 80) begin
      a = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
    end else if (shape < 88) begin
      a = $urandom();
      b = 32'd0;
      if ($urandom_range(0, 1) == 1) begin
        b = a;
        a = 32'd0;
      end
    end else if (shape < 94) begin
      a = $urandom();
      b = a;
    end else begin
      // Fibonacci number 47 is the largest that fits in 32 bits.
      steps = $urandom_range(1, 46);
      a = 32'd1;
      b = 32'd0;
      repeat (steps) begin
        fib_next = a + b;
        b = a;
        a = fib_next;
      end
      if ($urandom_range(0, 1) == 1) begin
        fib_next = a;
        a = b;
        b = fib_next;
      end
    end
    send_pair(a, b);
  endtask

  // The receiver holds out_stall high for a random stretch before each result word, with
  // occasional stretches where it takes every word at once.
  initial begin
    int stall_cycles;
    int run_left;
    logic receiver_quiet;
    receiver_quiet = 1'b0;
    run_left = 0;
    wait (rst_n);
    forever begin
      if (run_left == 0) begin
        receiver_quiet = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(10, 40);
      end
      run_left--;
      stall_cycles = receiver_quiet ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Main stimulus: reset, directed pairs, then the random pairs with a drain in the middle.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero operands on either side and both at once.
    send_pair(32'd0, 32'd0);
    send_pair(32'd0, 32'd12);
    send_pair(32'd35, 32'd0);
    send_pair(32'd0, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'd0);
    // Equal operands, including the largest value.
    send_pair(32'd1, 32'd1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000);
    // One against the largest value, in both orders.
    send_pair(32'd1, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'd1);
    // Neighbors are coprime; powers of two share their smaller one.
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_pair(32'h8000_0000, 32'h4000_0000);
    send_pair(32'h0000_0001, 32'h8000_0000);
    // Consecutive Fibonacci numbers need the most remainder steps.
    send_pair(32'd2971215073, 32'd1836311903);
    send_pair(32'd1836311903, 32'd2971215073);
    // Ordinary cases, mostly with a known common factor; the first pair in both orders.
    send_pair(32'd48, 32'd18);
    send_pair(32'd18, 32'd48);
    send_pair(32'd4294967291, 32'd4294967279);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'd65536 * 32'd3, 32'd65536 * 32'd5);

    wait_until_drained();

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 50 == 0) begin
        sender_quiet = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_PAIRS / 2) begin
        wait_until_drained();
      end
      send_random_pair();
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d operand pairs and checked %0d GCD words: zero, equal, extreme,",
             sent_pairs, checked_words);
    $display("power-of-two, shared-factor and Fibonacci pairs under random gaps and stalls.");
    if (fail_count == 0 && pending_words == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs, reporting the GCD words still expected.
  initial begin
    #5_000_000;
    $display("Timed out with %0d GCD words still expected", pending_words);
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gcd_pkg.sv
rtl/gcd_core.sv
rtl/gcd_euclidean_unit.sv
tb/gcd_result_checker.sv
tb/tb_gcd_euclidean_unit.sv
